### hdl/lkcd_pkg.sv
// shared types and constants for the lock order cycle detector
// no dependencies; used by lkcd_ctrl, lkcd_dp and lock_order_cycle_detector
package lkcd_pkg;

    localparam int NUM_LOCKS   = 16;
    localparam int STACK_DEPTH = 16;

    localparam int ID_W     = 4;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 5;

    localparam int LIDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W = $clog2(NUM_LOCKS + 1);

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POP_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEADLOCK     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HALTED       = 3'd5;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] lock_id;
    } t_evt;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                edge_added;
        logic [HELD_W-1:0]   held_count;
    } t_res;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic out_free;
    } t_dp_stat;

endpackage

### hdl/lock_order_cycle_detector.sv
// Lock order cycle detector, top level.
// Input channel (i_evt_valid / o_evt_ready / i_evt) carries acquire or release
// transactions with a lock id; output channel (o_res_valid / i_res_ready / o_res)
// returns one result per transaction: status, edge_added and held count.
// A transaction that records no new order edge has its result registered on
// acceptance, and while the receiver does not stall the next one can be taken
// right after it, so such traffic runs at one transaction per cycle.
// An acquire that records a new edge starts a reachability walk over the order
// matrix, one expansion step per cycle; it ends at a fixed point, which takes at
// most NUM_LOCKS - 1 growing steps; the input is not ready meanwhile, and the
// result waits for a free output register. The walk sets the worst case rate.
// Reset clears the held count, the order matrix and the halt flag; stack
// entries are written before they are read. After any error or a deadlock
// every later transaction answers halted until reset.
// When the receiver stalls, the result stays in the output register; one more
// transaction may still be accepted in the cycle the result is taken.
// Depends on lkcd_pkg, lkcd_ctrl, lkcd_dp.
module lock_order_cycle_detector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_evt_valid,
    output logic           o_evt_ready,
    input  lkcd_pkg::t_evt i_evt,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output lkcd_pkg::t_res o_res
);

    lkcd_pkg::t_dp_cmd  cmd;
    lkcd_pkg::t_dp_stat stat;

    lkcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt_valid),
        .o_evt_ready (o_evt_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lkcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_evt       (i_evt),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    // a deadlock is always reported on the transaction that added the edge
    a_deadlock_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == lkcd_pkg::ST_DEADLOCK) |-> o_res.edge_added)
        else $error("deadlock result without new edge");

    // no new transaction is taken while the walk is running
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_evt_ready && !cmd.accept)
        else $error("transaction accepted during walk");

    // finishing a walk always loads a result
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_res_valid && o_res.edge_added)
        else $error("walk finished without result");

    // held count never exceeds the stack depth
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (32'(o_res.held_count) <= lkcd_pkg::STACK_DEPTH))
        else $error("held count out of range");

endmodule

### hdl/lkcd_ctrl.sv
// controller: accepts transactions and sequences the reachability walk
// depends on lkcd_pkg
module lkcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_evt_valid,
    output logic              o_evt_ready,
    input  lkcd_pkg::t_dp_stat i_stat,
    output lkcd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state r_state;

    always_comb begin
        o_evt_ready   = (r_state == S_IDLE) && i_stat.out_free;
        o_cmd.accept  = o_evt_ready && i_evt_valid;
        o_cmd.step    = (r_state == S_WALK) && !i_stat.walk_done;
        o_cmd.finish  = (r_state == S_WALK) && i_stat.walk_done && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept && i_stat.need_walk) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (o_cmd.finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/lkcd_dp.sv
// datapath: held stack, lock order matrix, reach set walk and result register
// depends on lkcd_pkg
module lkcd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lkcd_pkg::t_dp_cmd  i_cmd,
    output lkcd_pkg::t_dp_stat o_stat,
    input  lkcd_pkg::t_evt     i_evt,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output lkcd_pkg::t_res     o_res
);

    logic [lkcd_pkg::ID_W-1:0]      r_stack [lkcd_pkg::STACK_DEPTH];
    logic [lkcd_pkg::CNT_W-1:0]     r_count;
    logic [lkcd_pkg::NUM_LOCKS-1:0] r_matrix [lkcd_pkg::NUM_LOCKS];
    logic [lkcd_pkg::NUM_LOCKS-1:0] r_reach;
    logic                           r_halted;
    logic [lkcd_pkg::LIDX_W-1:0]    r_top_idx;
    logic [lkcd_pkg::ID_W-1:0]      r_id;
    logic [lkcd_pkg::STEP_W-1:0]    r_step;
    logic                           r_res_valid;
    lkcd_pkg::t_res                 r_res;

    logic [lkcd_pkg::ID_W-1:0]      top;
    logic [lkcd_pkg::LIDX_W-1:0]    top_idx;
    logic [lkcd_pkg::LIDX_W-1:0]    id_idx;
    logic                           full;
    logic                           empty;
    logic                           top_in;
    logic                           id_in;
    logic                           need_walk;
    logic [lkcd_pkg::NUM_LOCKS-1:0] n_reach;
    logic                           hit;
    logic [lkcd_pkg::STATUS_W-1:0]  imm_status;
    logic                           imm_halt;
    logic                           imm_push;
    logic                           imm_pop;
    logic [lkcd_pkg::CNT_W-1:0]     imm_count;

    always_comb begin
        top     = r_stack[lkcd_pkg::SIDX_W'(r_count - lkcd_pkg::CNT_W'(1))];
        top_idx = lkcd_pkg::LIDX_W'(top);
        id_idx  = lkcd_pkg::LIDX_W'(i_evt.lock_id);
        full    = (32'(r_count) >= lkcd_pkg::STACK_DEPTH);
        empty   = (r_count == '0);
        top_in  = (32'(top) < lkcd_pkg::NUM_LOCKS);
        id_in   = (32'(i_evt.lock_id) < lkcd_pkg::NUM_LOCKS);
        need_walk = !r_halted && (i_evt.action == lkcd_pkg::ACT_ACQUIRE) && !full && !empty
                    && (top != i_evt.lock_id) && top_in && id_in
                    && !r_matrix[top_idx][id_idx];
    end

    // one expansion step: union of the rows of every lock reached so far
    always_comb begin
        n_reach = r_reach;
        for (int k = 0; k < lkcd_pkg::NUM_LOCKS; k++) begin
            if (r_reach[k]) begin
                n_reach = n_reach | r_matrix[k];
            end
        end
    end

    assign hit = r_reach[r_top_idx];

    always_comb begin
        imm_status = lkcd_pkg::ST_OK;
        imm_halt   = 1'b0;
        imm_push   = 1'b0;
        imm_pop    = 1'b0;
        if (r_halted) begin
            imm_status = lkcd_pkg::ST_HALTED;
        end else if (i_evt.action == lkcd_pkg::ACT_ACQUIRE) begin
            if (full) begin
                imm_status = lkcd_pkg::ST_FULL;
                imm_halt   = 1'b1;
            end else begin
                imm_push = 1'b1;
            end
        end else begin
            if (empty) begin
                imm_status = lkcd_pkg::ST_POP_EMPTY;
                imm_halt   = 1'b1;
            end else if (top != i_evt.lock_id) begin
                imm_status = lkcd_pkg::ST_POP_MISMATCH;
                imm_halt   = 1'b1;
            end else begin
                imm_pop = 1'b1;
            end
        end
        if (imm_push) begin
            imm_count = r_count + lkcd_pkg::CNT_W'(1);
        end else if (imm_pop) begin
            imm_count = r_count - lkcd_pkg::CNT_W'(1);
        end else begin
            imm_count = r_count;
        end
    end

    always_comb begin
        o_stat.need_walk = need_walk;
        o_stat.walk_done = (32'(r_step) == lkcd_pkg::NUM_LOCKS) || (n_reach == r_reach);
        o_stat.out_free  = !r_res_valid || i_res_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < lkcd_pkg::NUM_LOCKS; k++) begin
                r_matrix[k] <= '0;
            end
        end else begin
            // result held while stalled, loaded by a direct transaction or a finished walk
            r_res_valid <= (r_res_valid && !i_res_ready) || (i_cmd.accept && !need_walk)
                           || i_cmd.finish;
            if (i_cmd.accept) begin
                if (need_walk) begin
                    r_matrix[top_idx][id_idx] <= 1'b1;
                end else begin
                    r_count     <= imm_count;
                    r_halted    <= r_halted | imm_halt;
                end
            end
            if (i_cmd.finish) begin
                if (hit) begin
                    r_halted <= 1'b1;
                end else begin
                    r_count <= r_count + lkcd_pkg::CNT_W'(1);
                end
            end
        end
    end

    // payload: stack entries, walk registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (need_walk) begin
                r_reach   <= lkcd_pkg::NUM_LOCKS'(1) << id_idx;
                r_top_idx <= top_idx;
                r_id      <= i_evt.lock_id;
                r_step    <= '0;
            end else begin
                if (imm_push) begin
                    r_stack[lkcd_pkg::SIDX_W'(r_count)] <= i_evt.lock_id;
                end
                r_res.status     <= imm_status;
                r_res.edge_added <= 1'b0;
                r_res.held_count <= lkcd_pkg::HELD_W'(imm_count);
            end
        end
        if (i_cmd.step) begin
            r_reach <= n_reach;
            r_step  <= r_step + lkcd_pkg::STEP_W'(1);
        end
        if (i_cmd.finish) begin
            r_res.edge_added <= 1'b1;
            if (hit) begin
                r_res.status     <= lkcd_pkg::ST_DEADLOCK;
                r_res.held_count <= lkcd_pkg::HELD_W'(r_count);
            end else begin
                r_stack[lkcd_pkg::SIDX_W'(r_count)] <= r_id;
                r_res.status     <= lkcd_pkg::ST_OK;
                r_res.held_count <= lkcd_pkg::HELD_W'(r_count + lkcd_pkg::CNT_W'(1));
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### tb/testbench.sv
// testbench for lock_order_cycle_detector: drives acquire/release transactions,
// predicts each result from a local copy of the held stack and order matrix
// depends on lkcd_pkg and the lock_order_cycle_detector rtl
`timescale 1ns / 100ps

module testbench;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_evt_valid;
    logic           o_evt_ready;
    lkcd_pkg::t_evt i_evt;
    logic           o_res_valid;
    logic           i_res_ready;
    lkcd_pkg::t_res o_res;

    lock_order_cycle_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt_valid),
        .o_evt_ready (o_evt_ready),
        .i_evt       (i_evt),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always #10 i_clk = ~i_clk;

    // predicted lock state
    logic [lkcd_pkg::ID_W-1:0]      held_ids [lkcd_pkg::STACK_DEPTH];
    int unsigned                    held_n;
    logic [lkcd_pkg::NUM_LOCKS-1:0] order_rows [lkcd_pkg::NUM_LOCKS];
    bit                             lock_halted;

    lkcd_pkg::t_res pending_results [$];
    int             mismatch_count;
    int             gap_pct;
    int             stall_pct;

    // set of locks reachable from start through recorded order edges
    function automatic logic [lkcd_pkg::NUM_LOCKS-1:0] reach_from(int unsigned start);
        logic [lkcd_pkg::NUM_LOCKS-1:0] reach;
        logic [lkcd_pkg::NUM_LOCKS-1:0] grown;
        reach = '0;
        reach[start] = 1'b1;
        for (int s = 0; s < lkcd_pkg::NUM_LOCKS; s++) begin
            grown = reach;
            for (int k = 0; k < lkcd_pkg::NUM_LOCKS; k++) begin
                if (reach[k]) grown |= order_rows[k];
            end
            if (grown == reach) break;
            reach = grown;
        end
        return reach;
    endfunction

    function automatic lkcd_pkg::t_res lock_event_outcome(lkcd_pkg::t_evt ev);
        lkcd_pkg::t_res                 r;
        int unsigned                    top;
        logic [lkcd_pkg::NUM_LOCKS-1:0] reach;
        r.status     = lkcd_pkg::ST_OK;
        r.edge_added = 1'b0;
        if (lock_halted) begin
            r.status = lkcd_pkg::ST_HALTED;
        end else if (ev.action == lkcd_pkg::ACT_ACQUIRE) begin
            if (held_n >= lkcd_pkg::STACK_DEPTH) begin
                r.status    = lkcd_pkg::ST_FULL;
                lock_halted = 1'b1;
            end else begin
                if (held_n > 0) begin
                    top = held_ids[held_n-1];
                    if (top != ev.lock_id && top < lkcd_pkg::NUM_LOCKS &&
                        ev.lock_id < lkcd_pkg::NUM_LOCKS &&
                        !order_rows[top][ev.lock_id]) begin
                        order_rows[top][ev.lock_id] = 1'b1;
                        r.edge_added = 1'b1;
                        reach = reach_from(ev.lock_id);
                        if (reach[top]) begin
                            r.status    = lkcd_pkg::ST_DEADLOCK;
                            lock_halted = 1'b1;
                        end
                    end
                end
                // a deadlocking acquire is not pushed
                if (r.status == lkcd_pkg::ST_OK) begin
                    held_ids[held_n] = ev.lock_id;
                    held_n++;
                end
            end
        end else begin
            if (held_n == 0) begin
                r.status    = lkcd_pkg::ST_POP_EMPTY;
                lock_halted = 1'b1;
            end else if (held_ids[held_n-1] != ev.lock_id) begin
                r.status    = lkcd_pkg::ST_POP_MISMATCH;
                lock_halted = 1'b1;
            end else begin
                held_n--;
            end
        end
        r.held_count = lkcd_pkg::HELD_W'(held_n);
        return r;
    endfunction

    task automatic send_lock_event(input logic act, input logic [lkcd_pkg::ID_W-1:0] id);
        lkcd_pkg::t_evt ev;
        int             gap;
        ev.action  = act;
        ev.lock_id = id;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(11, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            i_evt_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_evt_valid <= 1'b1;
        i_evt       <= ev;
        do @(posedge i_clk); while (!o_evt_ready);
        pending_results.push_back(lock_event_outcome(ev));
    endtask

    task automatic release_top();
        send_lock_event(lkcd_pkg::ACT_RELEASE, held_ids[held_n-1]);
    endtask

    // extreme ids, re-acquire of the top lock, acquire over a recorded edge
    task automatic test_reacquire_and_extremes();
        send_lock_event(lkcd_pkg::ACT_ACQUIRE, 4'd0);
        send_lock_event(lkcd_pkg::ACT_ACQUIRE, 4'd0);
        send_lock_event(lkcd_pkg::ACT_ACQUIRE, 4'd15);
        send_lock_event(lkcd_pkg::ACT_RELEASE, 4'd15);
        send_lock_event(lkcd_pkg::ACT_ACQUIRE, 4'd15);
        send_lock_event(lkcd_pkg::ACT_RELEASE, 4'd15);
        send_lock_event(lkcd_pkg::ACT_RELEASE, 4'd0);
        send_lock_event(lkcd_pkg::ACT_RELEASE, 4'd0);
    endtask

    // fills the stack to its depth with a chain of new order edges
    task automatic test_ordered_chain();
        for (int i = 0; i < lkcd_pkg::STACK_DEPTH; i++) begin
            send_lock_event(lkcd_pkg::ACT_ACQUIRE, lkcd_pkg::ID_W'(i));
        end
        release_top();
    endtask

    // well-formed traffic; acquires that would close a cycle are always avoided
    task automatic test_random_traffic(input int count);
        int                             push_pct;
        logic [lkcd_pkg::ID_W-1:0]      id;
        int unsigned                    top;
        logic [lkcd_pkg::NUM_LOCKS-1:0] reach;
        bit                             closes;
        push_pct = 55;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(2))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 10; stall_pct = 15; end
                    default: begin gap_pct = 35; stall_pct = 35; end
                endcase
                push_pct = 35 + 20 * $urandom_range(2);
            end
            if (held_n == 0) begin
                send_lock_event(lkcd_pkg::ACT_ACQUIRE,
                                lkcd_pkg::ID_W'($urandom_range(lkcd_pkg::NUM_LOCKS-1)));
            end else if (held_n >= lkcd_pkg::STACK_DEPTH || $urandom_range(99) >= push_pct) begin
                release_top();
            end else begin
                top = held_ids[held_n-1];
                closes = 1'b1;
                for (int t = 0; t < 8 && closes; t++) begin
                    id = ($urandom_range(9) == 0) ? lkcd_pkg::ID_W'(top)
                                                  : lkcd_pkg::ID_W'($urandom_range(15));
                    reach = reach_from(id);
                    closes = (id != top) && !order_rows[top][id] && reach[top];
                end
                if (closes) id = lkcd_pkg::ID_W'(top);
                send_lock_event(lkcd_pkg::ACT_ACQUIRE, id);
            end
        end
    endtask

    // one error kind per run, since only reset clears the halt; then halted traffic
    task automatic test_error_halt();
        logic [lkcd_pkg::ID_W-1:0] a;
        logic [lkcd_pkg::ID_W-1:0] b;
        logic [lkcd_pkg::ID_W-1:0] t;
        gap_pct   = 0;
        stall_pct = 0;
        case ($urandom_range(3))
            0: begin
                while (held_n > 0) release_top();
                send_lock_event(lkcd_pkg::ACT_RELEASE, lkcd_pkg::ID_W'($urandom_range(15)));
            end
            1: begin
                if (held_n == 0) begin
                    send_lock_event(lkcd_pkg::ACT_ACQUIRE, lkcd_pkg::ID_W'($urandom_range(15)));
                end
                send_lock_event(lkcd_pkg::ACT_RELEASE,
                                held_ids[held_n-1] ^ lkcd_pkg::ID_W'($urandom_range(15, 1)));
            end
            2: begin
                if (held_n == 0) begin
                    send_lock_event(lkcd_pkg::ACT_ACQUIRE, lkcd_pkg::ID_W'($urandom_range(15)));
                end
                while (held_n < lkcd_pkg::STACK_DEPTH) begin
                    send_lock_event(lkcd_pkg::ACT_ACQUIRE, held_ids[held_n-1]);
                end
                send_lock_event(lkcd_pkg::ACT_ACQUIRE, lkcd_pkg::ID_W'($urandom_range(15)));
            end
            default: begin
                a = lkcd_pkg::ID_W'($urandom_range(15));
                b = a ^ lkcd_pkg::ID_W'($urandom_range(15, 1));
                while (held_n > 0) release_top();
                // second pass takes the pair in reverse order and must close a cycle
                for (int p = 0; p < 2 && !lock_halted; p++) begin
                    send_lock_event(lkcd_pkg::ACT_ACQUIRE, a);
                    send_lock_event(lkcd_pkg::ACT_ACQUIRE, b);
                    if (!lock_halted) begin
                        send_lock_event(lkcd_pkg::ACT_RELEASE, b);
                        send_lock_event(lkcd_pkg::ACT_RELEASE, a);
                    end
                    t = a;
                    a = b;
                    b = t;
                end
            end
        endcase
        repeat (24) begin
            send_lock_event(logic'($urandom_range(1)), lkcd_pkg::ID_W'($urandom_range(15)));
        end
    endtask

    // receiver with random stall bursts
    initial begin
        i_res_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(negedge i_clk);
                i_res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        lkcd_pkg::t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending: status %0d", o_res.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_res.status);
                    mismatch_count++;
                end
                if (o_res.edge_added !== want.edge_added) begin
                    $error("edge_added: expected %0d, actual %0d",
                           want.edge_added, o_res.edge_added);
                    mismatch_count++;
                end
                if (o_res.held_count !== want.held_count) begin
                    $error("held_count: expected %0d, actual %0d",
                           want.held_count, o_res.held_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_evt_valid    = 1'b0;
        i_evt          = '0;
        gap_pct        = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        held_n         = 0;
        lock_halted    = 1'b0;
        for (int i = 0; i < lkcd_pkg::NUM_LOCKS; i++) order_rows[i] = '0;
        for (int i = 0; i < lkcd_pkg::STACK_DEPTH; i++) held_ids[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reacquire_and_extremes();
        test_ordered_chain();
        test_random_traffic(1790);
        test_error_halt();

        @(negedge i_clk);
        i_evt_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (lkcd_pkg::NUM_LOCKS + 4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
